### sv/grid_line_max_subarray_sum_top_assert.svh
// Assertion macros shared by the grid line maximum segment sum modules.
`ifndef GRID_LINE_MAX_SUBARRAY_SUM_TOP_ASSERT_SVH
`define GRID_LINE_MAX_SUBARRAY_SUM_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLMSS_ASSERT_NOW(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// The consequent must hold in the cycle after the antecedent.
`define GLMSS_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

### sv/glmss_pkg.sv
// Shared constants and types of the grid line maximum segment sum block.
package glmss_pkg;

  localparam int DEF_MAX_DIM    = 2048;
  localparam int DEF_VALUE_BITS = 20;
  localparam int SIZE_W         = 12;
  localparam int OUT_W          = 30;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RST = SIZE_W'(2048);
  localparam logic [OUT_W-1:0]  OUT_MAX       = '1;

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_col;
    logic last_item;
  } glmss_flags_t;

endpackage

### sv/glmss_channels.sv
// Request channel interfaces for grid elements and grid results.
interface glmss_value_if #(
  parameter int W = glmss_pkg::DEF_VALUE_BITS
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface glmss_result_if;
  logic                         valid;
  logic                         ready;
  logic [glmss_pkg::OUT_W-1:0]  max_sum;

  modport source (output valid, output max_sum, input ready);
  modport sink (input valid, input max_sum, output ready);
endinterface

### sv/glmss_front.sv
// Front end: grid size register, raster position counters and element classification.
module glmss_front #(
  parameter int MAX_DIM    = glmss_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS = glmss_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [glmss_pkg::SIZE_W-1:0]    cfg_wdata,
  glmss_value_if.sink                     in_ch,
  output logic                            push_valid,
  input  logic                            push_ready,
  output logic signed [VALUE_BITS-1:0]    push_value,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] push_col,
  output glmss_pkg::glmss_flags_t         push_flags
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int CW = (NW > glmss_pkg::SIZE_W) ? NW : glmss_pkg::SIZE_W;

  logic [glmss_pkg::SIZE_W-1:0] grid_size_r;
  logic [AW-1:0]                col_r, col_nxt;
  logic [AW-1:0]                row_r, row_nxt;
  logic [CW-1:0]                size_ext;
  logic [NW-1:0]                n_eff;
  logic                         last_col;
  logic                         last_row;
  logic                         accept;

  assign size_ext = CW'(grid_size_r);

  always_comb begin
    if (size_ext == '0) begin
      n_eff = NW'(1);
    end else if (size_ext > CW'(MAX_DIM)) begin
      n_eff = NW'(MAX_DIM);
    end else begin
      n_eff = NW'(size_ext);
    end
  end

  assign last_col = (NW'(col_r) + NW'(1)) >= n_eff;
  assign last_row = (NW'(row_r) + NW'(1)) >= n_eff;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign push_value  = in_ch.value;
  assign push_col    = col_r;
  assign accept      = in_ch.valid && push_ready;

  assign push_flags.first_row = (row_r == '0);
  assign push_flags.first_col = (col_r == '0);
  assign push_flags.last_col  = last_col;
  assign push_flags.last_item = last_col && last_row;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : AW'(row_r + AW'(1));
      end else begin
        col_nxt = AW'(col_r + AW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= glmss_pkg::GRID_SIZE_RST;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      if (cfg_we) begin
        grid_size_r <= cfg_wdata;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  `include "grid_line_max_subarray_sum_top_assert.svh"

  `GLMSS_ASSERT_NEXT(a_grid_wrap, clk, rst_n, accept && push_flags.last_item,
    (col_r == '0) && (row_r == '0), "position counters did not wrap at grid end")

endmodule

### sv/glmss_queue.sv
// Short request queue that decouples the front end from the summing back end.
module glmss_queue #(
  parameter int W     = 8,
  parameter int DEPTH = glmss_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW = $clog2(DEPTH + 1);

  logic [W-1:0]  entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [KW-1:0] count_r;
  logic          push;
  logic          pop;

  assign push_ready = count_r != KW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + PW'(1));
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + PW'(1));
      end
      if (push && !pop) begin
        count_r <= KW'(count_r + KW'(1));
      end else if (pop && !push) begin
        count_r <= KW'(count_r - KW'(1));
      end
    end
  end

  `include "grid_line_max_subarray_sum_top_assert.svh"

  `GLMSS_ASSERT_NEXT(a_q_fill, clk, rst_n, push && !pop,
    count_r == KW'($past(count_r) + KW'(1)), "queue fill count did not advance on push")

endmodule

### sv/glmss_back.sv
// Back end: per-column run stores, four-way Kadane update, best tracking and result register.
module glmss_back #(
  parameter int MAX_DIM    = glmss_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS = glmss_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  logic signed [VALUE_BITS-1:0]    pop_value,
  input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] pop_col,
  input  glmss_pkg::glmss_flags_t         pop_flags,
  glmss_result_if.source                  out_ch
);

  localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int RUN_W = VALUE_BITS + AW + 1;
  localparam int BW    = RUN_W - 1;
  localparam int OUT_W = glmss_pkg::OUT_W;
  localparam int CMPW  = (BW > OUT_W) ? BW : OUT_W;

  logic signed [RUN_W-1:0] col_store_r  [MAX_DIM];
  logic signed [RUN_W-1:0] diag_store_r [MAX_DIM];
  logic signed [RUN_W-1:0] anti_store_r [MAX_DIM];

  logic                          s1_valid_r;
  logic signed [VALUE_BITS-1:0]  s1_value_r;
  logic [AW-1:0]                 s1_col_r;
  glmss_pkg::glmss_flags_t       s1_flags_r;
  logic signed [RUN_W-1:0]       col_rd_r, diag_rd_r, anti_rd_r;
  logic                          anti_byp_r;
  logic signed [RUN_W-1:0]       last_anti_r;
  logic signed [RUN_W-1:0]       diag_held_r;
  logic signed [RUN_W-1:0]       row_run_r;
  logic [BW-1:0]                 best_r, best_nxt;
  logic                          out_valid_r;
  logic [OUT_W-1:0]              out_sum_r;

  logic                          en;
  logic                          commit;
  logic [AW-1:0]                 anti_addr;
  logic signed [RUN_W-1:0]       x_ext, anti_prev;
  logic signed [RUN_W-1:0]       rs, cs, ds, as_run;
  logic signed [RUN_W-1:0]       m01, m23, m_all;
  logic [CMPW-1:0]               best_ext;
  logic [OUT_W-1:0]              sum_clamp;

  assign en        = !out_valid_r || out_ch.ready;
  assign commit    = en && s1_valid_r;
  assign pop_ready = en;
  assign anti_addr = AW'(pop_col + AW'(1));

  assign x_ext     = RUN_W'(s1_value_r);
  assign anti_prev = anti_byp_r ? last_anti_r : anti_rd_r;

  assign rs = (s1_flags_r.first_col || !(row_run_r > 0)) ? x_ext : row_run_r + x_ext;
  assign cs = (s1_flags_r.first_row || !(col_rd_r > 0)) ? x_ext : col_rd_r + x_ext;
  assign ds = (s1_flags_r.first_row || s1_flags_r.first_col || !(diag_held_r > 0)) ?
              x_ext : diag_held_r + x_ext;
  assign as_run = (s1_flags_r.first_row || s1_flags_r.last_col || !(anti_prev > 0)) ?
                  x_ext : anti_prev + x_ext;

  assign m01   = (cs > rs) ? cs : rs;
  assign m23   = (as_run > ds) ? as_run : ds;
  assign m_all = (m23 > m01) ? m23 : m01;

  assign best_nxt  = (m_all > $signed({1'b0, best_r})) ? BW'(m_all) : best_r;
  assign best_ext  = CMPW'(best_nxt);
  assign sum_clamp = (best_ext > CMPW'(glmss_pkg::OUT_MAX)) ? glmss_pkg::OUT_MAX :
                     OUT_W'(best_ext);

  assign out_ch.valid   = out_valid_r;
  assign out_ch.max_sum = out_sum_r;

  always_ff @(posedge clk) begin
    if (commit) begin
      col_store_r[s1_col_r] <= cs;
    end
    if (en) begin
      col_rd_r <= col_store_r[pop_col];
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      diag_store_r[s1_col_r] <= ds;
    end
    if (en) begin
      diag_rd_r <= diag_store_r[pop_col];
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      anti_store_r[s1_col_r] <= as_run;
    end
    if (en) begin
      anti_rd_r <= anti_store_r[anti_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_value_r <= pop_value;
      s1_col_r   <= pop_col;
      s1_flags_r <= pop_flags;
      anti_byp_r <= s1_valid_r && (s1_col_r == anti_addr);
    end
    if (commit) begin
      last_anti_r <= as_run;
    end
    if (commit && s1_flags_r.last_item) begin
      out_sum_r <= sum_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      best_r      <= '0;
      row_run_r   <= '0;
      diag_held_r <= '0;
    end else begin
      if (en) begin
        s1_valid_r <= pop_valid;
      end
      if (commit) begin
        row_run_r   <= s1_flags_r.last_item ? '0 : rs;
        diag_held_r <= s1_flags_r.last_item ? '0 : diag_rd_r;
        best_r      <= s1_flags_r.last_item ? '0 : best_nxt;
      end
      if (commit && s1_flags_r.last_item) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `include "grid_line_max_subarray_sum_top_assert.svh"

  `GLMSS_ASSERT_NEXT(a_grid_done, clk, rst_n, commit && s1_flags_r.last_item,
    out_valid_r && (best_r == '0), "grid end did not post a result and clear the best sum")
  `GLMSS_ASSERT_NEXT(a_stall_hold, clk, rst_n, s1_valid_r && !en,
    s1_valid_r && $stable(s1_col_r), "stalled element left the summing stage")
  `GLMSS_ASSERT_NOW(a_no_overrun, clk, rst_n, out_valid_r && !out_ch.ready,
    !commit, "element retired while the result register was blocked")

endmodule

### sv/grid_line_max_subarray_sum_top.sv
// Top level of the grid line maximum segment sum block.
// Elements of an n-by-n grid enter one per request in raster order, and one
// result with the largest row, column, diagonal or anti-diagonal segment sum
// (at least zero) leaves after the last element of each grid. The block takes
// one element per clock cycle while no posted result waits on out_ch.ready;
// this rate is set by the three per-column run stores, each read once and
// written once per cycle. No clearing pass is needed after reset. Change
// grid_size only while idle.
module grid_line_max_subarray_sum_top #(
  parameter int MAX_DIM    = glmss_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS = glmss_pkg::DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [glmss_pkg::SIZE_W-1:0] cfg_wdata,
  glmss_value_if.sink                  in_ch,
  glmss_result_if.source               out_ch
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int FW = $bits(glmss_pkg::glmss_flags_t);
  localparam int QW = VALUE_BITS + AW + FW;

  logic                          push_valid, push_ready;
  logic signed [VALUE_BITS-1:0]  push_value;
  logic [AW-1:0]                 push_col;
  glmss_pkg::glmss_flags_t       push_flags;
  logic                          pop_valid, pop_ready;
  logic [QW-1:0]                 pop_data;
  logic signed [VALUE_BITS-1:0]  pop_value;
  logic [AW-1:0]                 pop_col;
  glmss_pkg::glmss_flags_t       pop_flags;

  assign pop_value = pop_data[VALUE_BITS-1:0];
  assign pop_col   = pop_data[VALUE_BITS+AW-1:VALUE_BITS];
  assign pop_flags = pop_data[QW-1:VALUE_BITS+AW];

  glmss_front #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_value (push_value),
    .push_col   (push_col),
    .push_flags (push_flags)
  );

  glmss_queue #(
    .W     (QW),
    .DEPTH (glmss_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_flags, push_col, push_value}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  glmss_back #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_value (pop_value),
    .pop_col   (pop_col),
    .pop_flags (pop_flags),
    .out_ch    (out_ch)
  );

endmodule

### test/tb_grid_line_max_subarray_sum_top.sv
// Testbench for the grid line maximum segment sum block with a scoreboard.
module tb_grid_line_max_subarray_sum_top;

  localparam int MAX_DIM     = glmss_pkg::DEF_MAX_DIM;
  localparam int VALUE_BITS  = glmss_pkg::DEF_VALUE_BITS;
  localparam int SIZE_W      = glmss_pkg::SIZE_W;
  localparam int OUT_W       = glmss_pkg::OUT_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int RANDOM_GOAL = 1600;

  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum int {MIX_FULL, MIX_SMALL, MIX_NEGATIVE, MIX_POSITIVE, MIX_EXTREME} value_mix_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  glmss_value_if #(.W(VALUE_BITS)) in_if ();
  glmss_result_if                  out_if ();

  grid_line_max_subarray_sum_top #(
    .MAX_DIM   (MAX_DIM),
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // Predictor state, a copy of what the block holds.
  logic [SIZE_W-1:0] size_setting;
  longint            column_run [MAX_DIM];
  longint            diag_run [MAX_DIM];
  longint            anti_run [MAX_DIM];
  longint            row_run;
  longint            diag_carry;
  longint            best_run;
  int unsigned       row_pos;
  int unsigned       col_pos;

  logic signed [VALUE_BITS-1:0] pending_values [$];
  logic [OUT_W-1:0]             expected_sums [$];

  int  mismatches;
  int  cycle_count;
  int  random_items;
  bit  value_taken;
  bit  sum_taken;
  bit  pressure_phase;
  bit  long_hold_done;
  bit  send_burst;
  bit  recv_burst;
  int  send_gap;
  int  recv_wait;
  int  long_hold;
  bit  sum_ready;
  logic [OUT_W-1:0] predicted_sum;

  function automatic longint run_step(input bit restart, input longint prev, input longint x);
    if (restart) return x;
    return (prev + x > x) ? prev + x : x;
  endfunction

  function automatic bit predict_element(input logic signed [VALUE_BITS-1:0] raw,
                                         output logic [OUT_W-1:0] sum_out);
    int unsigned n;
    int unsigned r;
    int unsigned c;
    longint      x;
    longint      rs;
    longint      cs;
    longint      ds;
    longint      ads;
    longint      peak;
    bit          first_row;
    bit          last_col;
    n = (size_setting == 0) ? 1 : (size_setting > MAX_DIM) ? MAX_DIM : size_setting;
    r = row_pos;
    c = col_pos % MAX_DIM;
    x = longint'(raw);
    first_row = (r == 0);
    last_col = (c + 1 >= n);
    sum_out = '0;

    rs = run_step(c == 0, row_run, x);
    cs = run_step(first_row, column_run[c], x);
    ds = run_step(first_row || c == 0, diag_carry, x);
    ads = run_step(first_row || last_col, last_col ? 0 : anti_run[(c + 1) % MAX_DIM], x);

    diag_carry = diag_run[c];
    row_run = rs;
    column_run[c] = cs;
    diag_run[c] = ds;
    anti_run[c] = ads;

    peak = rs;
    if (cs > peak) peak = cs;
    if (ds > peak) peak = ds;
    if (ads > peak) peak = ads;
    if (peak > best_run) best_run = peak;

    if (!last_col) begin
      col_pos = c + 1;
      return 0;
    end
    col_pos = 0;
    if (r + 1 < n) begin
      row_pos = r + 1;
      return 0;
    end
    sum_out = (best_run > longint'(glmss_pkg::OUT_MAX)) ? glmss_pkg::OUT_MAX :
              best_run[OUT_W-1:0];
    row_run = 0;
    diag_carry = 0;
    best_run = 0;
    row_pos = 0;
    col_pos = 0;
    return 1;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] draw_value(input value_mix_t mix);
    int v;
    case (mix)
      MIX_FULL: begin
        v = int'($urandom);
      end
      MIX_SMALL: begin
        v = int'($urandom_range(0, 16)) - 8;
      end
      MIX_NEGATIVE: begin
        v = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 200000))
                                         : -int'($urandom_range(1, 524288));
      end
      MIX_POSITIVE: begin
        v = ($urandom_range(0, 4) == 0) ? -int'($urandom_range(1, 300000))
                                         : int'($urandom_range(0, 524287));
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = VALUE_MIN;
          1: v = VALUE_MAX;
          2: v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return VALUE_BITS'(v);
  endfunction

  task automatic append_value(input logic signed [VALUE_BITS-1:0] v);
    pending_values = {pending_values, v};
  endtask

  task automatic wait_idle();
    while (pending_values.size() != 0 || in_if.valid || expected_sums.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_grid_size(input logic [SIZE_W-1:0] setting);
    wait_idle();
    repeat (6) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= setting;
    @(negedge clk);
    cfg_we <= 1'b0;
    size_setting = setting;
    @(posedge clk);
  endtask

  task automatic queue_grids(input int n, input int grids);
    value_mix_t mix;
    for (int g = 0; g < grids; g++) begin
      mix = value_mix_t'($urandom_range(0, 4));
      for (int i = 0; i < n * n; i++) append_value(draw_value(mix));
      random_items += n * n;
    end
  endtask

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Each accepted element advances the predictor.
  always @(posedge clk) begin
    value_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      sum_ready = predict_element(in_if.value, predicted_sum);
      if (sum_ready) expected_sums = {expected_sums, predicted_sum};
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || value_taken) begin
      if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pending_values.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.value <= pending_values.pop_front();
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 15);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (sum_taken) begin
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 15);
      end
      if (pressure_phase && !long_hold_done) begin
        long_hold = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (long_hold > 0) begin
        out_if.ready <= 1'b0;
        long_hold = long_hold - 1;
      end else if (recv_wait > 0) begin
        out_if.ready <= 1'b0;
        recv_wait = recv_wait - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sum_taken <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_sums.size() == 0) begin
        $error("max_sum unexpected: expected none, actual %0d", out_if.max_sum);
        mismatches++;
      end else if (out_if.max_sum !== expected_sums[0]) begin
        $error("max_sum mismatch: expected %0d, actual %0d", expected_sums[0], out_if.max_sum);
        mismatches++;
        void'(expected_sums.pop_front());
      end else begin
        void'(expected_sums.pop_front());
      end
    end
  end

  initial begin
    int          diag_grid [9];
    int          anti_grid [9];
    int unsigned setting;
    int unsigned n;

    diag_grid = '{5, -9, 7, -9, 6, -9, 4, -9, 8};
    anti_grid = '{2, -9, 9, -9, 9, -9, 9, -9, 2};
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    out_if.ready = 1'b0;
    size_setting = glmss_pkg::GRID_SIZE_RST;
    row_run = 0;
    diag_carry = 0;
    best_run = 0;
    row_pos = 0;
    col_pos = 0;
    foreach (column_run[i]) begin
      column_run[i] = 0;
      diag_run[i] = 0;
      anti_run[i] = 0;
    end
    mismatches = 0;
    cycle_count = 0;
    random_items = 0;
    pressure_phase = 1'b0;
    long_hold_done = 1'b0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    send_gap = 0;
    recv_wait = 0;
    long_hold = 0;
    value_taken = 1'b0;
    sum_taken = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A zero size acts as a one-element grid.
    write_grid_size('0);
    append_value(VALUE_MAX);
    append_value(VALUE_MIN);
    append_value('0);
    write_grid_size(SIZE_W'(1));
    append_value(VALUE_BITS'(-1));
    write_grid_size(SIZE_W'(2));
    repeat (4) append_value(VALUE_MAX);
    write_grid_size(SIZE_W'(3));
    foreach (diag_grid[i]) append_value(VALUE_BITS'(diag_grid[i]));
    foreach (anti_grid[i]) append_value(VALUE_BITS'(anti_grid[i]));

    // Sizes beyond the store depth are clamped; a full grid of that size is too long to run.
    write_grid_size('1);
    write_grid_size(SIZE_W'(2048));

    write_grid_size(SIZE_W'(1));
    pressure_phase = 1'b1;
    queue_grids(1, 80);
    wait_idle();
    pressure_phase = 1'b0;

    write_grid_size(SIZE_W'(24));
    queue_grids(24, 1);

    while (random_items < RANDOM_GOAL) begin
      case ($urandom_range(0, 9))
        0: setting = 0;
        1: setting = $urandom_range(9, 16);
        default: setting = $urandom_range(1, 8);
      endcase
      n = (setting == 0) ? 1 : setting;
      write_grid_size(SIZE_W'(setting));
      queue_grids(n, $urandom_range(1, 3) + 64 / (n * n));
    end

    wait_idle();
    repeat (12) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
